[hw/rtl/touch_report_decode_recovery_defines.svh]
// Assertion macros for the touch report decoder.
// Used by the top level; expects clk and rst_n to be in scope where expanded.
`ifndef TOUCH_REPORT_DECODE_RECOVERY_DEFINES_SVH
`define TOUCH_REPORT_DECODE_RECOVERY_DEFINES_SVH
`ifndef ASSERT_OFF
`define TRD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("touch report decoder: assertion failed");
`define TRD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("touch report decoder: forbidden condition seen");
`else
`define TRD_ASSERT(label, prop)
`define TRD_ASSERT_NEVER(label, cond)
`endif
`endif

[hw/rtl/trd_pkg.sv]
// Shared types and constants for the touch report decoder.
// No dependencies; used by every module of the block.
package trd_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FAIL_THRESHOLD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCALATE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_X_EN        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR_Y_EN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP_AXES_EN       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_X_LIMIT            = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LIMIT            = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT_CAPACITY     = 3'd7;

    // Register reset values.
    localparam logic [15:0] FAIL_THRESHOLD_DEFAULT     = 16'd5;
    localparam logic [15:0] ESCALATE_THRESHOLD_DEFAULT = 16'd3;
    localparam logic [7:0]  POINT_CAPACITY_DEFAULT     = 8'd1;

    // Recovery action codes.
    localparam logic [1:0] ACT_NONE        = 2'd0;
    localparam logic [1:0] ACT_HW_RESET    = 2'd1;
    localparam logic [1:0] ACT_POWER_CYCLE = 2'd2;

    // Report byte layout.
    localparam int         TOUCH_VALID_BIT    = 7;
    localparam logic [7:0] STATUS_NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic [15:0] fail_threshold;
        logic [15:0] escalate_threshold;
        logic        mirror_x_en;
        logic        mirror_y_en;
        logic        swap_axes_en;
        logic [15:0] x_limit;
        logic [15:0] y_limit;
        logic [7:0]  point_capacity;
    } cfg_t;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] coord_high;
        logic [7:0] x_low_byte;
        logic [7:0] y_low_byte;
        logic       status_ok;
        logic [7:0] status_byte;
    } poll_t;

    typedef struct packed {
        logic [1:0] action;
        logic       rewrite;
    } recov_t;

    typedef struct packed {
        logic        count;
        logic [15:0] x;
        logic [15:0] y;
    } point_t;

endpackage

[hw/rtl/trd_point.sv]
// Coordinate decode, mirror and swap, with the held touch point.
// Depends on trd_pkg.
module trd_point
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  trd_pkg::poll_t poll,
    input  trd_pkg::cfg_t  cfg,
    output trd_pkg::point_t report
);

    logic [15:0] held_x_reg, held_x_next;
    logic [15:0] held_y_reg, held_y_next;
    logic        held_points_reg, held_points_next;
    logic [15:0] raw_x, raw_y, mir_x, mir_y;
    logic        count;

    // Unpack the 11-bit coordinates and apply the optional mirroring.
    assign raw_x = {5'd0, poll.coord_high[6:4], poll.x_low_byte};
    assign raw_y = {5'd0, poll.coord_high[2:0], poll.y_low_byte};
    assign mir_x = cfg.mirror_x_en ? (cfg.x_limit - raw_x) : raw_x;
    assign mir_y = cfg.mirror_y_en ? (cfg.y_limit - raw_y) : raw_y;

    // A successful read replaces the held point; a failed one keeps it.
    always_comb
    begin
        held_x_next      = held_x_reg;
        held_y_next      = held_y_reg;
        held_points_next = held_points_reg;
        if (poll.read_ok)
        begin
            if (poll.coord_high[trd_pkg::TOUCH_VALID_BIT])
            begin
                held_x_next      = cfg.swap_axes_en ? mir_y : mir_x;
                held_y_next      = cfg.swap_axes_en ? mir_x : mir_y;
                held_points_next = 1'b1;
            end
            else
            begin
                held_x_next      = 16'd0;
                held_y_next      = 16'd0;
                held_points_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg      <= 16'd0;
            held_y_reg      <= 16'd0;
            held_points_reg <= 1'b0;
        end
        else if (step)
        begin
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            held_points_reg <= held_points_next;
        end
    end

    // The report shows the point as it stands after this poll.
    assign count        = held_points_next && (cfg.point_capacity != 8'd0);
    assign report.count = count;
    assign report.x     = count ? held_x_next : 16'd0;
    assign report.y     = count ? held_y_next : 16'd0;

endmodule

[hw/rtl/trd_recovery.sv]
// Failure counting, reset escalation and periodic status checking.
// Depends on trd_pkg.
module trd_recovery
#(
    parameter int STATUS_CHECK_PERIOD = 200
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  trd_pkg::poll_t  poll,
    input  trd_pkg::cfg_t   cfg,
    output trd_pkg::recov_t recov
);

    localparam logic [8:0] PERIOD = 9'(STATUS_CHECK_PERIOD);

    logic [15:0] fail_count_reg, fail_count_next;
    logic [15:0] reset_count_reg, reset_count_next;
    logic [7:0]  check_tick_reg, check_tick_next;
    logic [15:0] fail_inc;
    logic [8:0]  tick_inc;

    assign fail_inc = fail_count_reg + 16'd1;
    assign tick_inc = {1'b0, check_tick_reg} + 9'd1;

    always_comb
    begin
        fail_count_next  = fail_count_reg;
        reset_count_next = reset_count_reg;
        check_tick_next  = check_tick_reg;
        recov.action     = trd_pkg::ACT_NONE;
        recov.rewrite    = 1'b0;
        if (!poll.read_ok)
        begin
            // Consecutive failure: recover once the threshold is reached.
            fail_count_next = fail_inc;
            if (fail_inc >= cfg.fail_threshold)
            begin
                if (reset_count_reg >= cfg.escalate_threshold)
                begin
                    recov.action     = trd_pkg::ACT_POWER_CYCLE;
                    reset_count_next = 16'd0;
                end
                else
                begin
                    recov.action     = trd_pkg::ACT_HW_RESET;
                    reset_count_next = reset_count_reg + 16'd1;
                end
                recov.rewrite   = 1'b1;
                fail_count_next = 16'd0;
            end
        end
        else
        begin
            // Good read: clear the counters and check status on the first tick.
            fail_count_next  = 16'd0;
            reset_count_next = 16'd0;
            if ((check_tick_reg == 8'd0) && poll.status_ok
                && ((poll.status_byte & trd_pkg::STATUS_NIBBLE_MASK) != 8'd0))
            begin
                recov.rewrite = 1'b1;
            end
            check_tick_next = (tick_inc >= PERIOD) ? 8'd0 : tick_inc[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count_reg  <= 16'd0;
            reset_count_reg <= 16'd0;
            check_tick_reg  <= 8'd0;
        end
        else if (step)
        begin
            fail_count_reg  <= fail_count_next;
            reset_count_reg <= reset_count_next;
            check_tick_reg  <= check_tick_next;
        end
    end

endmodule

[hw/rtl/touch_report_decode_recovery.sv]
// Touch report decoder with read-failure recovery: top level.
// Depends on trd_pkg, trd_point, trd_recovery and the defines header.
//
// Usage: each input transfer (in_valid/in_ready) carries one controller poll.
// Each poll gives exactly one result transfer (out_valid/out_ready) with the
// decoded point, the read-failed flag, any recovery action and the idle
// rewrite request. The poll is captured in an input register, decoded
// against the counter and point state, and written to the result
// register, from which its result is offered. Throughput is one poll per
// cycle while the receiver keeps taking results: the input register refills
// in the same cycle that it hands its poll to the result register.
// If the receiver stalls, the result register holds its transfer and the
// input register takes one further poll; in_ready then drops until the
// result is taken. Configuration is written through cfg_we/cfg_index/cfg_data
// while no poll is in flight.
// Reset clears both valid flags, the counters and the held point, and
// returns every configuration register to its default.
`include "touch_report_decode_recovery_defines.svh"

module touch_report_decode_recovery
#(
    parameter int STATUS_CHECK_PERIOD = 200
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Poll input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        read_ok,
    input  logic [7:0]  coord_high,
    input  logic [7:0]  x_low_byte,
    input  logic [7:0]  y_low_byte,
    input  logic        status_ok,
    input  logic [7:0]  status_byte,
    // Result output channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic        read_failed,
    output logic        point_count,
    output logic [15:0] x_out,
    output logic [15:0] y_out,
    output logic [1:0]  recovery_action,
    output logic        rewrite_idle
);

    typedef struct packed {
        logic            read_failed;
        trd_pkg::point_t point;
        trd_pkg::recov_t recov;
    } result_t;

    trd_pkg::cfg_t   cfg_reg;
    trd_pkg::poll_t  poll_reg;
    logic            in_valid_reg;
    result_t         res_reg;
    logic            out_valid_reg;
    logic            step;
    trd_pkg::point_t point;
    trd_pkg::recov_t recov;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fail_threshold     <= trd_pkg::FAIL_THRESHOLD_DEFAULT;
            cfg_reg.escalate_threshold <= trd_pkg::ESCALATE_THRESHOLD_DEFAULT;
            cfg_reg.mirror_x_en        <= 1'b0;
            cfg_reg.mirror_y_en        <= 1'b0;
            cfg_reg.swap_axes_en       <= 1'b0;
            cfg_reg.x_limit            <= 16'd0;
            cfg_reg.y_limit            <= 16'd0;
            cfg_reg.point_capacity     <= trd_pkg::POINT_CAPACITY_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trd_pkg::REG_FAIL_THRESHOLD:     cfg_reg.fail_threshold     <= cfg_data;
                trd_pkg::REG_ESCALATE_THRESHOLD: cfg_reg.escalate_threshold <= cfg_data;
                trd_pkg::REG_MIRROR_X_EN:        cfg_reg.mirror_x_en        <= cfg_data[0];
                trd_pkg::REG_MIRROR_Y_EN:        cfg_reg.mirror_y_en        <= cfg_data[0];
                trd_pkg::REG_SWAP_AXES_EN:       cfg_reg.swap_axes_en       <= cfg_data[0];
                trd_pkg::REG_X_LIMIT:            cfg_reg.x_limit            <= cfg_data;
                trd_pkg::REG_Y_LIMIT:            cfg_reg.y_limit            <= cfg_data;
                trd_pkg::REG_POINT_CAPACITY:     cfg_reg.point_capacity     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The held poll moves on whenever the result register is free or emptying.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            poll_reg.read_ok     <= read_ok;
            poll_reg.coord_high  <= coord_high;
            poll_reg.x_low_byte  <= x_low_byte;
            poll_reg.y_low_byte  <= y_low_byte;
            poll_reg.status_ok   <= status_ok;
            poll_reg.status_byte <= status_byte;
        end
    end

    trd_point u_point
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .poll   (poll_reg),
        .cfg    (cfg_reg),
        .report (point)
    );

    trd_recovery
    #(
        .STATUS_CHECK_PERIOD (STATUS_CHECK_PERIOD)
    )
    u_recovery
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .poll  (poll_reg),
        .cfg   (cfg_reg),
        .recov (recov)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg.read_failed <= !poll_reg.read_ok;
            res_reg.point       <= point;
            res_reg.recov       <= recov;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_failed     = res_reg.read_failed;
    assign point_count     = res_reg.point.count;
    assign x_out           = res_reg.point.x;
    assign y_out           = res_reg.point.y;
    assign recovery_action = res_reg.recov.action;
    assign rewrite_idle    = res_reg.recov.rewrite;

    // A good read never asks for a recovery action.
    `TRD_ASSERT(a_no_action_on_good_read,
        (out_valid && !read_failed) |-> (recovery_action == trd_pkg::ACT_NONE))
    // Any recovery action comes with an idle rewrite request.
    `TRD_ASSERT(a_action_implies_rewrite,
        (out_valid && (recovery_action != trd_pkg::ACT_NONE)) |-> rewrite_idle)
    // An empty report carries a zero point.
    `TRD_ASSERT(a_empty_point_zero,
        (out_valid && !point_count) |-> ((x_out == 16'd0) && (y_out == 16'd0)))
    // The input side is never blocked while the result register is empty.
    `TRD_ASSERT_NEVER(a_ready_when_empty, !out_valid_reg && !in_ready)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for touch_report_decode_recovery: directed and random polls,
// each checked against a behavioural decoder kept in step with the block's registers.
// Depends on trd_pkg and the block's RTL only.

module tb_top;

    localparam int CHECK_PERIOD = 200;
    localparam int MAX_WAIT     = 14;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_POLLS  = 153;
    localparam int RUN_CAP      = 30;

    typedef struct packed {
        logic        read_failed;
        logic        point_count;
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  action;
        logic        rewrite;
    } report_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    trd_pkg::poll_t                  cur_poll  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            read_failed;
    logic                            point_count;
    logic [15:0]                     x_out;
    logic [15:0]                     y_out;
    logic [1:0]                      recovery_action;
    logic                            rewrite_idle;

    // Polls waiting to be sent and reports waiting to arrive.
    trd_pkg::poll_t poll_backlog[$];
    report_t        pending_reports[$];

    // Shadow of the block's registers and state.
    trd_pkg::cfg_t   shadow_cfg;
    logic [15:0]     fail_run    = '0;
    logic [15:0]     reset_tries = '0;
    logic [7:0]      status_tick = '0;
    trd_pkg::point_t held_pt     = '0;

    int issued       = 0;
    int accepted     = 0;
    int taken        = 0;
    int taken_seen   = 0;
    int send_gap     = 0;
    int recv_stall   = 0;
    int errors       = 0;
    int quiet_cycles = 0;
    bit no_idling    = 1'b0;

    touch_report_decode_recovery #(
        .STATUS_CHECK_PERIOD(CHECK_PERIOD)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .read_ok         (cur_poll.read_ok),
        .coord_high      (cur_poll.coord_high),
        .x_low_byte      (cur_poll.x_low_byte),
        .y_low_byte      (cur_poll.y_low_byte),
        .status_ok       (cur_poll.status_ok),
        .status_byte     (cur_poll.status_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_failed     (read_failed),
        .point_count     (point_count),
        .x_out           (x_out),
        .y_out           (y_out),
        .recovery_action (recovery_action),
        .rewrite_idle    (rewrite_idle)
    );

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Decode one accepted poll and advance the shadow state.
    function automatic report_t decode_poll(input trd_pkg::poll_t p);
        report_t     r;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] tmp;
        r = '0;
        r.action = trd_pkg::ACT_NONE;
        if (!p.read_ok)
        begin
            fail_run = fail_run + 16'd1;
            if (fail_run >= shadow_cfg.fail_threshold)
            begin
                if (reset_tries >= shadow_cfg.escalate_threshold)
                begin
                    r.action = trd_pkg::ACT_POWER_CYCLE;
                    reset_tries = '0;
                end
                else
                begin
                    r.action = trd_pkg::ACT_HW_RESET;
                    reset_tries = reset_tries + 16'd1;
                end
                r.rewrite = 1'b1;
                fail_run = '0;
            end
        end
        else
        begin
            fail_run = '0;
            reset_tries = '0;
            // The status nibble is only looked at on the first read of each period.
            if (status_tick == 8'd0 && p.status_ok &&
                (p.status_byte & trd_pkg::STATUS_NIBBLE_MASK) != 8'd0)
                r.rewrite = 1'b1;
            if (int'(status_tick) + 1 >= CHECK_PERIOD)
                status_tick = 8'd0;
            else
                status_tick = status_tick + 8'd1;

            if (p.coord_high[trd_pkg::TOUCH_VALID_BIT])
            begin
                px = {5'd0, p.coord_high[6:4], p.x_low_byte};
                py = {5'd0, p.coord_high[2:0], p.y_low_byte};
                if (shadow_cfg.mirror_x_en)
                    px = shadow_cfg.x_limit - px;
                if (shadow_cfg.mirror_y_en)
                    py = shadow_cfg.y_limit - py;
                if (shadow_cfg.swap_axes_en)
                begin
                    tmp = px;
                    px = py;
                    py = tmp;
                end
                held_pt.x = px;
                held_pt.y = py;
                held_pt.count = 1'b1;
            end
            else
                held_pt = '0;
        end
        r.read_failed = !p.read_ok;
        r.point_count = held_pt.count && (shadow_cfg.point_capacity != 8'd0);
        r.x = r.point_count ? held_pt.x : 16'd0;
        r.y = r.point_count ? held_pt.y : 16'd0;
        return r;
    endfunction

    function automatic int draw_wait();
        return no_idling ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic trd_pkg::poll_t make_poll(input logic ok, input logic [7:0] hi,
                                                 input logic [7:0] xl, input logic [7:0] yl,
                                                 input logic sok, input logic [7:0] st);
        trd_pkg::poll_t p;
        p.read_ok = ok;
        p.coord_high = hi;
        p.x_low_byte = xl;
        p.y_low_byte = yl;
        p.status_ok = sok;
        p.status_byte = st;
        return p;
    endfunction

    // A poll with random content; the read flag and the touch bit are chosen.
    function automatic trd_pkg::poll_t make_touch(input logic ok, input logic touched);
        trd_pkg::poll_t p;
        p = make_poll(ok, 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(0, 3) != 0, 8'($urandom));
        p.coord_high[trd_pkg::TOUCH_VALID_BIT] = touched;
        return p;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors = errors + 1;
        end
    endtask

    // Write one register at the next rising edge and mirror it in the shadow.
    task automatic write_reg(input logic [trd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        case (idx)
            trd_pkg::REG_FAIL_THRESHOLD:     shadow_cfg.fail_threshold = value;
            trd_pkg::REG_ESCALATE_THRESHOLD: shadow_cfg.escalate_threshold = value;
            trd_pkg::REG_MIRROR_X_EN:        shadow_cfg.mirror_x_en = value[0];
            trd_pkg::REG_MIRROR_Y_EN:        shadow_cfg.mirror_y_en = value[0];
            trd_pkg::REG_SWAP_AXES_EN:       shadow_cfg.swap_axes_en = value[0];
            trd_pkg::REG_X_LIMIT:            shadow_cfg.x_limit = value;
            trd_pkg::REG_Y_LIMIT:            shadow_cfg.y_limit = value;
            trd_pkg::REG_POINT_CAPACITY:     shadow_cfg.point_capacity = value[7:0];
            default:                         ;
        endcase
    endtask

    // Write every register; the narrow ones get random upper bits.
    task automatic apply_settings(input logic [15:0] thr, input logic [15:0] esc,
                                  input logic mx, input logic my, input logic sw,
                                  input logic [15:0] xl, input logic [15:0] yl,
                                  input logic [7:0] cap);
        write_reg(trd_pkg::REG_FAIL_THRESHOLD, thr);
        write_reg(trd_pkg::REG_ESCALATE_THRESHOLD, esc);
        write_reg(trd_pkg::REG_MIRROR_X_EN, {15'($urandom), mx});
        write_reg(trd_pkg::REG_MIRROR_Y_EN, {15'($urandom), my});
        write_reg(trd_pkg::REG_SWAP_AXES_EN, {15'($urandom), sw});
        write_reg(trd_pkg::REG_X_LIMIT, xl);
        write_reg(trd_pkg::REG_Y_LIMIT, yl);
        write_reg(trd_pkg::REG_POINT_CAPACITY, {8'($urandom), cap});
        cfg_we = 1'b0;
    endtask

    // Hold off until every poll has been sent and every report has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (poll_backlog.size() != 0 || issued != accepted || pending_reports.size() != 0);
    endtask

    // Mostly runs of good reads and runs of failures; a failure run may be long enough to escalate, capped at RUN_CAP.
    task automatic queue_random(input int count);
        int left;
        int kind;
        int len;
        int cap;
        left = count;
        cap = (int'(shadow_cfg.fail_threshold) + 1) * (int'(shadow_cfg.escalate_threshold) + 2);
        if (cap > RUN_CAP)
            cap = RUN_CAP;
        while (left > 0)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                len = $urandom_range(1, 6);
                repeat (len) poll_backlog.push_back(make_touch(1'b1, $urandom_range(0, 4) != 0));
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, cap);
                repeat (len) poll_backlog.push_back(make_touch(1'b0, 1'($urandom_range(0, 1))));
            end
            else
            begin
                len = 1;
                poll_backlog.push_back(make_touch(1'($urandom_range(0, 1)),
                                                  1'($urandom_range(0, 1))));
            end
            left = left - len;
        end
    endtask

    // Poll driver: a new transfer is offered once the previous one is taken and
    // its gap has run out.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (issued == accepted)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (poll_backlog.size() != 0)
            begin
                cur_poll <= poll_backlog.pop_front();
                in_valid <= 1'b1;
                issued = issued + 1;
                send_gap = draw_wait();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict the report for each accepted poll.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            pending_reports.push_back(decode_poll(cur_poll));
            accepted = accepted + 1;
        end
    end

    // Result receiver: stall for a random number of cycles after each transfer.
    always @(negedge clk)
    begin
        if (taken != taken_seen)
        begin
            taken_seen = taken;
            recv_stall = draw_wait();
        end
        if (recv_stall > 0)
        begin
            recv_stall = recv_stall - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin : report_monitor
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            taken = taken + 1;
            if (pending_reports.size() == 0)
            begin
                $error("result transfer with no prediction waiting");
                errors = errors + 1;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("read_failed", 16'(want.read_failed), 16'(read_failed));
                check_field("point_count", 16'(want.point_count), 16'(point_count));
                check_field("x_out", want.x, x_out);
                check_field("y_out", want.y, y_out);
                check_field("recovery_action", 16'(want.action), 16'(recovery_action));
                check_field("rewrite_idle", 16'(want.rewrite), 16'(rewrite_idle));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase;
        logic [15:0] thr;
        logic [15:0] esc;
        logic [15:0] xl;
        logic [15:0] yl;
        logic [7:0]  cap;

        shadow_cfg.fail_threshold = trd_pkg::FAIL_THRESHOLD_DEFAULT;
        shadow_cfg.escalate_threshold = trd_pkg::ESCALATE_THRESHOLD_DEFAULT;
        shadow_cfg.mirror_x_en = 1'b0;
        shadow_cfg.mirror_y_en = 1'b0;
        shadow_cfg.swap_axes_en = 1'b0;
        shadow_cfg.x_limit = '0;
        shadow_cfg.y_limit = '0;
        shadow_cfg.point_capacity = trd_pkg::POINT_CAPACITY_DEFAULT;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Defaults: first good read with a failed status read and no touch,
        // coordinate extremes, then enough failures to escalate to a power cycle.
        poll_backlog.push_back(make_poll(1'b1, 8'h08, 8'hAA, 8'h55, 1'b0, 8'h0F));
        poll_backlog.push_back(make_poll(1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hF0));
        poll_backlog.push_back(make_poll(1'b1, 8'h80, 8'h00, 8'h00, 1'b1, 8'h0F));
        for (int i = 0; i < 20; i++)
        begin
            if (i % 2 == 0)
                poll_backlog.push_back(make_poll(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
            else
                poll_backlog.push_back(make_poll(1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00));
        end
        wait_idle();

        // Zero thresholds, mirroring that wraps, swapped axes.
        apply_settings(16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 16'h0000, 16'hFFFF, 8'hFF);
        poll_backlog.push_back(make_poll(1'b1, 8'hF7, 8'hFF, 8'h00, 1'b1, 8'h01));
        poll_backlog.push_back(make_poll(1'b0, 8'h7F, 8'h12, 8'h34, 1'b1, 8'h0F));
        poll_backlog.push_back(make_poll(1'b0, 8'h80, 8'h00, 8'hFF, 1'b0, 8'hFF));
        wait_idle();

        // Random phases, each under new settings; the first two use the extremes.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                thr = 16'd1;
                esc = 16'd1;
                xl = 16'h0000;
                yl = 16'h0000;
                cap = 8'd0;
            end
            else if (phase == 1)
            begin
                thr = 16'hFFFF;
                esc = 16'hFFFF;
                xl = 16'hFFFF;
                yl = 16'hFFFF;
                cap = 8'hFF;
            end
            else
            begin
                thr = 16'($urandom_range(0, 6));
                esc = 16'($urandom_range(0, 4));
                xl = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'd2047;
                yl = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'd2047;
                cap = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            end
            apply_settings(thr, esc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), xl, yl, cap);
            no_idling = (phase % 3 == 2);
            queue_random(PHASE_POLLS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
